FILE: src/kmrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrs_pkg
// Shared types, constants and the keyword compare function of the
// keyword match risk scorer.
// ----------------------------------------------------------------------------
package kmrs_pkg;

    localparam int NUM_KW    = 17;
    localparam int HIST_LEN  = 13;
    localparam int HIST_BITS = 8 * HIST_LEN;

    // Keyword classes, one bit per keyword in mask order.
    localparam logic [NUM_KW-1:0] SHELL_MASK   = 17'h00003;
    localparam logic [NUM_KW-1:0] SCRIPT_MASK  = 17'h00020;
    localparam logic [NUM_KW-1:0] DROPPER_MASK = 17'h00600;
    localparam logic [NUM_KW-1:0] OTHER_MASK   = 17'h1F9DC;

    // Register reset values.
    localparam logic [7:0] RST_WEIGHT_SHELL   = 8'd30;
    localparam logic [7:0] RST_WEIGHT_SCRIPT  = 8'd25;
    localparam logic [7:0] RST_WEIGHT_DROPPER = 8'd40;
    localparam logic [7:0] RST_WEIGHT_OTHER   = 8'd10;
    localparam logic [7:0] RST_SCORE_CAP      = 8'd100;

    // Register indexes on the config port.
    typedef enum logic [2:0] {
        REG_WEIGHT_SHELL   = 3'd0,
        REG_WEIGHT_SCRIPT  = 3'd1,
        REG_WEIGHT_DROPPER = 3'd2,
        REG_WEIGHT_OTHER   = 3'd3,
        REG_SCORE_CAP      = 3'd4
    } kmrs_reg_idx_t;

    typedef struct packed {
        logic [7:0] shell;
        logic [7:0] script_tag;
        logic [7:0] dropper;
        logic [7:0] other;
        logic [7:0] cap;
    } kmrs_weights_t;

    // Window holds the newest byte in bits [7:0]; a keyword of length L
    // matches when the low 8*L bits equal its text (last char lowest).
    function automatic logic [NUM_KW-1:0] kmrs_hits(input logic [HIST_BITS-1:0] win);
        logic [NUM_KW-1:0] h;
        h[0]  = (win[79:0]   == "powershell");
        h[1]  = (win[55:0]   == "cmd.exe");
        h[2]  = (win[55:0]   == "wscript");
        h[3]  = (win[55:0]   == "cscript");
        h[4]  = (win[31:0]   == "bash");
        h[5]  = (win[63:0]   == "<script>");
        h[6]  = (win[87:0]   == "javascript:");
        h[7]  = (win[55:0]   == "onload=");
        h[8]  = (win[63:0]   == "onerror=");
        h[9]  = (win[55:0]   == "dropper");
        h[10] = (win[55:0]   == "payload");
        h[11] = (win[55:0]   == "exploit");
        h[12] = (win[71:0]   == "shellcode");
        h[13] = (win[103:0]  == {"base64", "_decode"});
        h[14] = (win[39:0]   == "eval(");
        h[15] = (win[39:0]   == "exec(");
        h[16] = (win[55:0]   == "system(");
        return h;
    endfunction

endpackage

FILE: src/kmrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrs_front
// Byte history shift register, parallel keyword compare and sticky flags.
// Pushes the final mask into the result queue on each end-of-file item.
// ----------------------------------------------------------------------------
module kmrs_front
    import kmrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  logic              end_of_file,
    output logic              push,
    output logic [NUM_KW-1:0] push_mask
);

    logic [HIST_BITS-1:0] hist_reg;
    logic [HIST_BITS-1:0] hist_next;
    logic [NUM_KW-1:0]    flags_reg;
    logic [NUM_KW-1:0]    flags_next;
    logic [HIST_BITS-1:0] win;
    logic [NUM_KW-1:0]    hits;
    logic [NUM_KW-1:0]    mask_now;

    assign win      = {hist_reg[HIST_BITS-9:0], data_byte};
    assign hits     = kmrs_hits(win);
    assign mask_now = byte_valid ? (flags_reg | hits) : flags_reg;

    assign push      = accept && end_of_file;
    assign push_mask = mask_now;

    always_comb
    begin
        hist_next  = hist_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            if (end_of_file)
            begin
                hist_next  = '0;
                flags_next = '0;
            end
            else if (byte_valid)
            begin
                hist_next  = win;
                flags_next = mask_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            hist_reg  <= hist_next;
            flags_reg <= flags_next;
        end
    end

endmodule

FILE: src/kmrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrs_queue
// Small FIFO of finished match masks between the front and the back.
// ----------------------------------------------------------------------------
module kmrs_queue
    import kmrs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [NUM_KW-1:0] push_mask,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [NUM_KW-1:0] pop_mask
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [NUM_KW-1:0] mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_mask  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/kmrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmrs_back
// Two-stage scoring pipeline: per-class counts times weights, then sum,
// saturate and hold in the output register.
// ----------------------------------------------------------------------------
module kmrs_back
    import kmrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  kmrs_weights_t     weights,
    input  logic              q_valid,
    input  logic [NUM_KW-1:0] q_mask,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [NUM_KW-1:0] match_mask,
    output logic              suspicious,
    output logic [7:0]        risk_score
);

    logic              mid_valid_reg;
    logic [NUM_KW-1:0] mid_mask_reg;
    logic [11:0]       p_shell_reg;
    logic [11:0]       p_script_reg;
    logic [11:0]       p_drop_reg;
    logic [11:0]       p_other_reg;

    logic              out_valid_reg;
    logic [NUM_KW-1:0] mask_reg;
    logic              susp_reg;
    logic [7:0]        score_reg;

    logic              out_adv;
    logic              mid_ready;
    logic [1:0]        n_shell;
    logic [1:0]        n_script;
    logic [1:0]        n_drop;
    logic [3:0]        n_other;
    logic [12:0]       sum;
    logic [7:0]        score;

    assign out_adv   = !out_valid_reg || !out_stall;
    assign mid_ready = !mid_valid_reg || out_adv;
    assign q_pop     = q_valid && mid_ready;

    assign n_shell  = 2'($countones(q_mask & SHELL_MASK));
    assign n_script = 2'($countones(q_mask & SCRIPT_MASK));
    assign n_drop   = 2'($countones(q_mask & DROPPER_MASK));
    assign n_other  = 4'($countones(q_mask & OTHER_MASK));

    assign sum   = 13'(p_shell_reg) + 13'(p_script_reg) + 13'(p_drop_reg)
                 + 13'(p_other_reg);
    assign score = (sum > 13'(weights.cap)) ? weights.cap : sum[7:0];

    always_ff @(posedge clk)
    begin
        if (mid_ready)
        begin
            mid_mask_reg <= q_mask;
            p_shell_reg  <= 12'(weights.shell) * 12'(n_shell);
            p_script_reg <= 12'(weights.script_tag) * 12'(n_script);
            p_drop_reg   <= 12'(weights.dropper) * 12'(n_drop);
            p_other_reg  <= 12'(weights.other) * 12'(n_other);
        end
        if (out_adv)
        begin
            mask_reg  <= mid_mask_reg;
            susp_reg  <= (mid_mask_reg != '0);
            score_reg <= score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_ready)
            begin
                mid_valid_reg <= q_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign match_mask = mask_reg;
    assign suspicious = susp_reg;
    assign risk_score = score_reg;

endmodule

FILE: src/keyword_match_risk_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_match_risk_scorer
// Scans a byte stream for 17 fixed keywords and reports a weighted score
// per file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per cycle carrying
//   data_byte, byte_valid and end_of_file. Items with byte_valid set shift
//   into a 13-byte history that is compared against all keywords in
//   parallel each cycle; hits set sticky flags. An item with end_of_file
//   set closes the file and produces one result; byte_valid low on it
//   means a bare end marker.
//   Output channel (out_valid / out_stall): match_mask, suspicious and
//   risk_score. Results pass the result queue, product stage and output register.
//   Throughput: one item per cycle while in_stall is low. in_stall rises only when the
//   result queue (QUEUE_DEPTH entries) is full, i.e. when the receiver has
//   stalled long enough for that many results to pile up.
//   Config: cfg_we / cfg_index / cfg_data write the weights and score cap;
//   write only while idle. Unknown indexes are ignored.
//   Reset: history, flags, queue and pipeline clear; registers go to their
//   default weights (30, 25, 40, 10) and cap 100.
// ----------------------------------------------------------------------------
module keyword_match_risk_scorer
    import kmrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  logic              end_of_file,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [NUM_KW-1:0] match_mask,
    output logic              suspicious,
    output logic [7:0]        risk_score,
    // config write port
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    kmrs_weights_t     weights_reg;
    logic              in_accept;
    logic              q_full;
    logic              q_push;
    logic [NUM_KW-1:0] q_push_mask;
    logic              q_pop;
    logic              q_valid;
    logic [NUM_KW-1:0] q_mask;

    // Front stalls only on a full queue, so the history never blocks on
    // the output side.
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    // Config registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.shell      <= RST_WEIGHT_SHELL;
            weights_reg.script_tag <= RST_WEIGHT_SCRIPT;
            weights_reg.dropper    <= RST_WEIGHT_DROPPER;
            weights_reg.other      <= RST_WEIGHT_OTHER;
            weights_reg.cap        <= RST_SCORE_CAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT_SHELL:   weights_reg.shell      <= cfg_data;
                REG_WEIGHT_SCRIPT:  weights_reg.script_tag <= cfg_data;
                REG_WEIGHT_DROPPER: weights_reg.dropper    <= cfg_data;
                REG_WEIGHT_OTHER:   weights_reg.other      <= cfg_data;
                REG_SCORE_CAP:      weights_reg.cap        <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Front: history and keyword flags.
    kmrs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .end_of_file (end_of_file),
        .push        (q_push),
        .push_mask   (q_push_mask)
    );

    // Queue of finished masks.
    kmrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_mask (q_push_mask),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_mask  (q_mask)
    );

    // Back: scoring pipeline and output register.
    kmrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .weights    (weights_reg),
        .q_valid    (q_valid),
        .q_mask     (q_mask),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .match_mask (match_mask),
        .suspicious (suspicious),
        .risk_score (risk_score)
    );

`ifndef SYNTHESIS
    // A taken end item always leaves a mask in the queue.
    a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_file |=> q_valid)
        else $error("end item did not reach the result queue");

    // Suspicious flag agrees with the mask it goes with.
    a_susp_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (suspicious == (match_mask != '0)))
        else $error("suspicious flag disagrees with match mask");

    // Score never exceeds the cap.
    a_score_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (risk_score <= weights_reg.cap))
        else $error("risk score above cap");
`endif

endmodule
